/* hdl/pnsd_pkg.sv */
// ----------------------------------------------------------------------------
// pnsd_pkg: shared types and constants for the packed name string decoder
// Holds the result record, mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package pnsd_pkg;

  // Results one input byte can cause at most
  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned RES_CNT_W = 2;

  // Decode modes carried with every byte
  localparam logic [1:0] MODE_LOWER5   = 2'd0;
  localparam logic [1:0] MODE_MIXED6   = 2'd1;
  localparam logic [1:0] MODE_FIRST_UP = 2'd2;
  localparam logic [1:0] MODE_ESC_UP   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_ONE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_TWO = 1'd1;

  // Register reset values ('.' and '_')
  localparam logic [7:0] SPECIAL_ONE_RST = 8'd46;
  localparam logic [7:0] SPECIAL_TWO_RST = 8'd95;

  // One result record
  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       end_of_string;
    logic       bad_code;
  } result_t;

endpackage

/* hdl/pnsd_decode.sv */
// ----------------------------------------------------------------------------
// pnsd_decode: code extraction and character decode for one byte
// Holds the per-string state and turns the registered byte into up to three
// result records in a single combinational pass.
// ----------------------------------------------------------------------------
module pnsd_decode (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  logic [7:0]                            data_byte,
  input  logic [1:0]                            mode,
  input  logic                                  last_byte,
  input  logic [7:0]                            special_one,
  input  logic [7:0]                            special_two,
  output pnsd_pkg::result_t [pnsd_pkg::MAX_RES-1:0] res,
  output logic [pnsd_pkg::RES_CNT_W-1:0]        res_cnt
);

  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_DIGIT_0 = 8'd48;
  localparam logic [7:0] CH_DOT     = 8'd46;
  localparam logic [7:0] CH_UNDER   = 8'd95;
  localparam logic [7:0] CH_DOLLAR  = 8'd36;
  localparam logic [7:0] CH_BAR     = 8'd124;
  localparam logic [7:0] CASE_DIFF  = 8'd32;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } dec_t;

  // Map one code to its character under the given mode
  function automatic dec_t decode_char(input logic [5:0] code, input logic [1:0] md,
                                       input logic [7:0] s1, input logic [7:0] s2);
    dec_t d;
    d.ok = 1'b1;
    d.ch = '0;
    if (code <= 6'd25) begin
      d.ch = 8'(code) + CH_LOWER_A;
    end else if (md == pnsd_pkg::MODE_MIXED6) begin
      if (code <= 6'd51) begin
        d.ch = 8'(code - 6'd26) + CH_UPPER_A;
      end else if (code <= 6'd61) begin
        d.ch = 8'(code - 6'd52) + CH_DIGIT_0;
      end else if (code == 6'd62) begin
        d.ch = s1;
      end else begin
        d.ch = s2;
      end
    end else begin
      unique case (code)
        6'd26:   d.ch = CH_DOT;
        6'd27:   d.ch = CH_UNDER;
        6'd28:   d.ch = CH_DOLLAR;
        6'd29:   d.ch = CH_BAR;
        default: d.ok = 1'b0;
      endcase
    end
    return d;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      u = c - CASE_DIFF;
    end
    return u;
  endfunction

  // String state
  logic [4:0] rem_r;
  logic [2:0] cnt_r;
  logic [5:0] held_r;
  logic       held_vld_r;
  logic       strip_r;
  logic       at_start_r;
  logic       first_pend_r;
  logic       esc_pend_r;
  logic       discard_r;

  // Extraction signals
  logic [12:0] buf_w;
  logic [3:0]  n_bits;
  logic [3:0]  width;
  logic [3:0]  two_width;
  logic [12:0] mask13;
  logic        k1;
  logic        k2;
  logic [3:0]  sh1;
  logic [3:0]  sh2;
  logic [3:0]  rest;
  logic [5:0]  code1;
  logic [5:0]  code2;
  logic [5:0]  held_nxt;
  logic [4:0]  rem_nxt;
  logic        strip_nxt;

  // Release signals
  logic [pnsd_pkg::MAX_RES-1:0] slot_vld;
  logic [5:0]                   slot_code [pnsd_pkg::MAX_RES];
  logic                         failed;
  logic                         esc_nxt;
  logic                         first_nxt;
  dec_t                         dc;
  logic [pnsd_pkg::RES_CNT_W-1:0] n_res;

  // Line up the held bits and the new byte, then cut out up to two codes
  always_comb begin
    if (at_start_r) begin
      buf_w  = {6'd0, data_byte[6:0]};
      n_bits = 4'd7;
    end else begin
      buf_w  = {rem_r, data_byte};
      n_bits = 4'(cnt_r) + 4'd8;
    end
    width     = (mode == pnsd_pkg::MODE_MIXED6) ? 4'd6 : 4'd5;
    two_width = width << 1;
    mask13    = (mode == pnsd_pkg::MODE_MIXED6) ? 13'h3F : 13'h1F;
    k1        = n_bits >= width;
    k2        = n_bits >= two_width;
    sh1       = n_bits - width;
    sh2       = n_bits - two_width;
    code1     = 6'((buf_w >> sh1) & mask13);
    code2     = 6'((buf_w >> sh2) & mask13);
    if (k2) begin
      rest = sh2;
    end else if (k1) begin
      rest = sh1;
    end else begin
      rest = n_bits;
    end
    rem_nxt   = 5'(buf_w & ((13'd1 << rest) - 13'd1));
    held_nxt  = k2 ? code2 : (k1 ? code1 : held_r);
    strip_nxt = at_start_r ? data_byte[7] : strip_r;
  end

  // Release the held code, the first new code, and at the end the last one
  always_comb begin
    slot_vld[0]  = !discard_r && held_vld_r && k1;
    slot_code[0] = held_r;
    slot_vld[1]  = !discard_r && k2;
    slot_code[1] = code1;
    slot_vld[2]  = !discard_r && last_byte && !strip_nxt && (held_vld_r || k1);
    slot_code[2] = held_nxt;
  end

  // Decode released codes in order, tracking escape and first-letter flags
  always_comb begin
    res       = '0;
    n_res     = '0;
    failed    = 1'b0;
    esc_nxt   = esc_pend_r;
    first_nxt = first_pend_r;
    dc        = '0;
    for (int j = 0; j < int'(pnsd_pkg::MAX_RES); j++) begin
      if (slot_vld[j] && !failed) begin
        dc = decode_char(slot_code[j], mode, special_one, special_two);
        if (!dc.ok) begin
          res[n_res].end_of_string = 1'b1;
          res[n_res].bad_code      = 1'b1;
          n_res  = n_res + 2'd1;
          failed = 1'b1;
        end else begin
          if (esc_nxt) begin
            esc_nxt = 1'b0;
            res[n_res].character = upcase(dc.ch);
            res[n_res].has_char  = 1'b1;
            n_res = n_res + 2'd1;
          end else if (mode == pnsd_pkg::MODE_ESC_UP && dc.ch == CH_BAR) begin
            esc_nxt = 1'b1;
          end else if (mode == pnsd_pkg::MODE_FIRST_UP && first_nxt) begin
            res[n_res].character = upcase(dc.ch);
            res[n_res].has_char  = 1'b1;
            n_res = n_res + 2'd1;
          end else begin
            res[n_res].character = dc.ch;
            res[n_res].has_char  = 1'b1;
            n_res = n_res + 2'd1;
          end
          first_nxt = 1'b0;
        end
      end
    end
    // Mark the end of the string, or add an empty end record
    if (last_byte && !discard_r && !failed) begin
      if (n_res != '0) begin
        res[n_res - 2'd1].end_of_string = 1'b1;
      end else begin
        res[0].end_of_string = 1'b1;
        n_res = 2'd1;
      end
    end
  end

  assign res_cnt = n_res;

  // Advance the string state once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_byte)) begin
      rem_r        <= '0;
      cnt_r        <= '0;
      held_r       <= '0;
      held_vld_r   <= 1'b0;
      strip_r      <= 1'b0;
      at_start_r   <= 1'b1;
      first_pend_r <= 1'b1;
      esc_pend_r   <= 1'b0;
      discard_r    <= 1'b0;
    end else if (fire && !discard_r) begin
      if (failed) begin
        discard_r <= 1'b1;
      end else begin
        rem_r        <= rem_nxt;
        cnt_r        <= 3'(rest);
        held_r       <= held_nxt;
        held_vld_r   <= held_vld_r || k1;
        strip_r      <= strip_nxt;
        at_start_r   <= 1'b0;
        first_pend_r <= first_nxt;
        esc_pend_r   <= esc_nxt;
      end
    end
  end

endmodule

/* hdl/pnsd_burst.sv */
// ----------------------------------------------------------------------------
// pnsd_burst: result buffer and output register
// Takes the up to three records of one byte at once and hands them to the
// output register one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module pnsd_burst (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  pnsd_pkg::result_t [pnsd_pkg::MAX_RES-1:0] load_res,
  input  logic [pnsd_pkg::RES_CNT_W-1:0]        load_cnt,
  output logic                                  free,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pnsd_pkg::result_t                     out_res
);

  pnsd_pkg::result_t [pnsd_pkg::MAX_RES-1:0] slot_r;
  logic [pnsd_pkg::RES_CNT_W-1:0]            cnt_r;
  pnsd_pkg::result_t                         out_r;
  logic                                      out_valid_r;
  logic                                      emit;

  assign emit = (cnt_r != '0) && (!out_valid_r || out_ready);
  assign free = (cnt_r == '0) || (cnt_r == 2'd1 && emit);

  // Hold the records of one byte; shift down as each one leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (emit) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= load_res;
    end else if (emit) begin
      for (int j = 0; j < int'(pnsd_pkg::MAX_RES) - 1; j++) begin
        slot_r[j] <= slot_r[j+1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= slot_r[0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("burst loaded while records still pending");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted record did not reach output register");

endmodule

/* hdl/packed_name_string_decoder_unit.sv */
// ----------------------------------------------------------------------------
// packed_name_string_decoder_unit: packed name string to ASCII decoder
// Input register, single-pass decode, result buffer and output register.
// ----------------------------------------------------------------------------
// A byte is taken into the input register, decoded combinationally into zero to
// three result records that load the result buffer, and those records leave
// through the output register one per cycle unless out_ready stalls them. Bytes
// that cause no result pass at one per cycle while the buffer is empty; else the
// next byte waits until the buffer emits its last record, as the output port is
// single-record. A byte causes up to three records, three only on a final byte.
// The user must write special_one and special_two through the cfg port (index 0
// and 1) only while no request is in flight; the block does not enforce this.
module packed_name_string_decoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic [1:0]                     in_mode,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_character,
  output logic                           out_has_char,
  output logic                           out_end_of_string,
  output logic                           out_bad_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pnsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic [1:0] mode_r;
  logic       last_r;
  logic [7:0] special_one_r;
  logic [7:0] special_two_r;
  logic       in_accept;
  logic       dec_fire;
  logic       burst_free;

  pnsd_pkg::result_t [pnsd_pkg::MAX_RES-1:0] dec_res;
  logic [pnsd_pkg::RES_CNT_W-1:0]            dec_cnt;
  pnsd_pkg::result_t                         out_res;

  assign dec_fire  = in_valid_r && burst_free;
  assign in_ready  = !in_valid_r || dec_fire;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      special_one_r <= pnsd_pkg::SPECIAL_ONE_RST;
      special_two_r <= pnsd_pkg::SPECIAL_TWO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pnsd_pkg::CFG_SPECIAL_ONE: special_one_r <= cfg_data;
        pnsd_pkg::CFG_SPECIAL_TWO: special_two_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold the request until the decoder takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (dec_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= in_data_byte;
      mode_r <= in_mode;
      last_r <= in_last_byte;
    end
  end

  pnsd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (dec_fire),
    .data_byte   (byte_r),
    .mode        (mode_r),
    .last_byte   (last_r),
    .special_one (special_one_r),
    .special_two (special_two_r),
    .res         (dec_res),
    .res_cnt     (dec_cnt)
  );

  pnsd_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (dec_fire),
    .load_res  (dec_res),
    .load_cnt  (dec_cnt),
    .free      (burst_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_character     = out_res.character;
  assign out_has_char      = out_res.has_char;
  assign out_end_of_string = out_res.end_of_string;
  assign out_bad_code      = out_res.bad_code;

  a_bad_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_code |-> out_end_of_string && !out_has_char)
    else $error("bad code record without end of string");

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_char |-> out_end_of_string && out_character == 8'd0)
    else $error("record without character is not a clean end marker");

  a_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !dec_fire |=> in_valid_r && $stable(byte_r))
    else $error("stalled request dropped from input register");

endmodule

/* sim/packed_name_string_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_name_string_decoder_unit_tb: self-checking bench for the decoder
// Drives packed name strings through the request channel in random bursts,
// predicts the characters of every byte from its own decoder model and
// checks each result in order while the result side stalls on its own
// pattern. Directed strings cover the code tables, the strip flag, all four
// modes, bad codes and both special registers; random strings follow.
// ----------------------------------------------------------------------------
module packed_name_string_decoder_unit_tb;

  localparam int unsigned IDLE_GAP   = 8;
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned RAND_ITEMS = 450;

  // Character constants of the code tables
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_ESCAPE  = 8'h7C;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [7:0]                     in_data_byte;
  logic [1:0]                     in_mode;
  logic                           in_last_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic [7:0]                     out_character;
  logic                           out_has_char;
  logic                           out_end_of_string;
  logic                           out_bad_code;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [pnsd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_data;

  // Decoder model state and register copies
  logic [15:0] pend_bits;
  int          pend_cnt;
  logic [5:0]  held_code;
  logic        held_vld;
  logic        strip_on;
  logic        str_start;
  logic        first_pend;
  logic        esc_pend;
  logic        skipping;
  logic [7:0]  spec_one;
  logic [7:0]  spec_two;

  // Characters still due from the block, oldest first
  pnsd_pkg::result_t chars_due[$];
  pnsd_pkg::result_t byte_res[$];
  logic              byte_bad;
  logic [5:0]        code_buf[$];

  int burst_left;
  int items_live;
  int strings_sent;
  int results_seen;
  int bad_ends;
  int cfg_writes;
  int err_count;
  int idle_cycles;
  int stall_left;
  int stall_style;

  packed_name_string_decoder_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_mode          (in_mode),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_character    (out_character),
    .out_has_char     (out_has_char),
    .out_end_of_string(out_end_of_string),
    .out_bad_code     (out_bad_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic pnsd_pkg::result_t make_result(input logic [7:0] ch, input logic has,
                                                    input logic fin, input logic bad);
    pnsd_pkg::result_t r;
    r.character     = ch;
    r.has_char      = has;
    r.end_of_string = fin;
    r.bad_code      = bad;
    return r;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - 8'd32 : c;
  endfunction

  // Map a code to its character; return 0 for a code with no character
  function automatic logic lookup_char(input logic [5:0] code, input logic [1:0] m,
                                       output logic [7:0] ch);
    ch = 8'h00;
    lookup_char = 1'b1;
    if (code <= 6'd25) begin
      ch = CH_LOWER_A + {2'b00, code};
    end else if (m == pnsd_pkg::MODE_MIXED6) begin
      if (code <= 6'd51) ch = CH_UPPER_A + {2'b00, code - 6'd26};
      else if (code <= 6'd61) ch = CH_DIGIT_0 + {2'b00, code - 6'd52};
      else if (code == 6'd62) ch = spec_one;
      else ch = spec_two;
    end else begin
      case (code)
        6'd26: ch = CH_DOT;
        6'd27: ch = CH_USCORE;
        6'd28: ch = CH_DOLLAR;
        6'd29: ch = CH_ESCAPE;
        default: lookup_char = 1'b0;
      endcase
    end
  endfunction

  task automatic emit(input pnsd_pkg::result_t r);
    if (byte_res.size() < pnsd_pkg::MAX_RES) byte_res.insert(byte_res.size(), r);
  endtask

  task automatic clear_string();
    pend_bits  = '0;
    pend_cnt   = 0;
    held_code  = '0;
    held_vld   = 1'b0;
    strip_on   = 1'b0;
    str_start  = 1'b1;
    first_pend = 1'b1;
    esc_pend   = 1'b0;
    skipping   = 1'b0;
  endtask

  // Decode the held code with the mode of the releasing byte
  task automatic release_held(input logic [1:0] m);
    logic [7:0] ch;
    if (!lookup_char(held_code, m, ch)) begin
      emit(make_result(8'h00, 1'b0, 1'b1, 1'b1));
      byte_bad = 1'b1;
      return;
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      emit(make_result(upcase(ch), 1'b1, 1'b0, 1'b0));
    end else if (m == pnsd_pkg::MODE_ESC_UP && ch == CH_ESCAPE) begin
      esc_pend = 1'b1;
    end else if (m == pnsd_pkg::MODE_FIRST_UP && first_pend) begin
      emit(make_result(upcase(ch), 1'b1, 1'b0, 1'b0));
    end else begin
      emit(make_result(ch, 1'b1, 1'b0, 1'b0));
    end
    first_pend = 1'b0;
  endtask

  // Work out the characters one accepted byte causes and queue them
  task automatic decode_byte(input logic [7:0] b, input logic [1:0] m, input logic fin);
    int                w;
    logic [5:0]        msk;
    logic [15:0]       acc;
    int                nbits;
    logic [5:0]        code;
    pnsd_pkg::result_t r;
    byte_res.delete();
    byte_bad = 1'b0;
    if (skipping) begin
      if (fin) clear_string();
      return;
    end
    w   = (m == pnsd_pkg::MODE_MIXED6) ? 6 : 5;
    msk = (m == pnsd_pkg::MODE_MIXED6) ? 6'h3F : 6'h1F;
    if (str_start) begin
      strip_on  = b[7];
      acc       = {9'd0, b[6:0]};
      nbits     = 7;
      str_start = 1'b0;
    end else begin
      acc   = {pend_bits[7:0], b};
      nbits = pend_cnt + 8;
    end
    // Extract complete codes, each one releasing the code before it
    while (nbits >= w && !byte_bad) begin
      code  = 6'(acc >> (nbits - w)) & msk;
      nbits = nbits - w;
      acc   = acc & ((16'd1 << nbits) - 16'd1);
      if (held_vld) release_held(m);
      held_code = code;
      held_vld  = 1'b1;
    end
    pend_bits = acc;
    pend_cnt  = nbits;
    if (byte_bad) begin
      if (fin) clear_string();
      else skipping = 1'b1;
    end else if (fin) begin
      if (!strip_on && held_vld) release_held(m);
      if (!byte_bad) begin
        if (byte_res.size() > 0) begin
          r = byte_res[byte_res.size()-1];
          r.end_of_string = 1'b1;
          byte_res[byte_res.size()-1] = r;
        end else begin
          emit(make_result(8'h00, 1'b0, 1'b1, 1'b0));
        end
      end
      clear_string();
    end
    foreach (byte_res[i]) chars_due.insert(chars_due.size(), byte_res[i]);
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Send one byte; open a new burst after a random gap when the last one ran out
  task automatic send_byte(input logic [7:0] b, input logic [1:0] m, input logic fin);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_mode      <= m;
    in_last_byte <= fin;
    do @(posedge clk); while (!in_ready);
    items_live++;
    decode_byte(b, m, fin);
  endtask

  // Pack code_buf behind the strip flag and send it as one string
  task automatic send_packed(input logic strip, input logic [1:0] m, input logic mode_noise);
    logic [255:0] stream;
    int           w;
    int           pos;
    int           nbytes;
    logic [1:0]   bm;
    w      = (m == pnsd_pkg::MODE_MIXED6) ? 6 : 5;
    stream = '0;
    pos    = 255;
    stream[pos] = strip;
    pos--;
    foreach (code_buf[i]) begin
      for (int k = w - 1; k >= 0; k--) begin
        stream[pos] = code_buf[i][k];
        pos--;
      end
    end
    nbytes = (1 + code_buf.size() * w + 7) / 8;
    // Fill the tail of the final byte with random bits
    while (pos > 255 - nbytes * 8) begin
      stream[pos] = 1'($urandom_range(0, 1));
      pos--;
    end
    for (int j = 0; j < nbytes; j++) begin
      bm = mode_noise ? 2'($urandom_range(0, 3)) : m;
      send_byte(stream[255 - 8 * j -: 8], bm, j == nbytes - 1);
    end
    strings_sent++;
  endtask

  // Hold off requests until every character is back and the block is quiet
  task automatic settle_block();
    @(negedge clk);
    in_valid  <= 1'b0;
    burst_left = 0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_special(input logic [pnsd_pkg::CFG_IDX_W-1:0] idx,
                               input logic [7:0] val);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pnsd_pkg::CFG_SPECIAL_ONE) spec_one = val;
    else spec_two = val;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern, checking and hang watchdog
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left  = $urandom_range(16, 64);
    end
    stall_left--;
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (stall_left % 5 == 0);
    endcase
  end

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    pnsd_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (chars_due.size() == 0) begin
        note_mismatch("unexpected result", out_character, 8'h00);
      end else begin
        want = chars_due.pop_front();
        if (want.bad_code) bad_ends++;
        if (out_character !== want.character)
          note_mismatch("character", out_character, want.character);
        if (out_has_char !== want.has_char)
          note_mismatch("has_char", 8'(out_has_char), 8'(want.has_char));
        if (out_end_of_string !== want.end_of_string)
          note_mismatch("end_of_string", 8'(out_end_of_string), 8'(want.end_of_string));
        if (out_bad_code !== want.bad_code)
          note_mismatch("bad_code", 8'(out_bad_code), 8'(want.bad_code));
      end
    end
    // Count cycles without any handshake
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still due", $realtime,
                 HANG_LIMIT, chars_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Mixed mode at reset: both specials, table edges of every range
  task automatic test_specials_at_reset();
    code_buf = '{6'd62, 6'd63, 6'd0, 6'd25, 6'd26, 6'd51, 6'd52, 6'd61};
    send_packed(1'b0, pnsd_pkg::MODE_MIXED6, 1'b0);
  endtask

  // Plain 5-bit with all punctuation; strip drops the final code
  task automatic test_lower5_strip();
    code_buf = '{6'd0, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29};
    send_packed(1'b1, pnsd_pkg::MODE_LOWER5, 1'b0);
  endtask

  // First upper: punctuation consumes the first flag, then a letter first
  task automatic test_first_upper();
    code_buf = '{6'd26, 6'd1, 6'd2};
    send_packed(1'b0, pnsd_pkg::MODE_FIRST_UP, 1'b0);
    code_buf = '{6'd3, 6'd4};
    send_packed(1'b0, pnsd_pkg::MODE_FIRST_UP, 1'b0);
  endtask

  // Escape upper: escaped letter, escaped escape, trailing escape
  task automatic test_escape_upper();
    code_buf = '{6'd29, 6'd0, 6'd29, 6'd29, 6'd29};
    send_packed(1'b0, pnsd_pkg::MODE_ESC_UP, 1'b0);
  endtask

  // Bad codes: mid-string with discard on last, and at the very start
  task automatic test_bad_code();
    code_buf = '{6'd1, 6'd30, 6'd2, 6'd3};
    send_packed(1'b0, pnsd_pkg::MODE_LOWER5, 1'b0);
    code_buf = '{6'd31, 6'd1, 6'd1, 6'd1};
    send_packed(1'b0, pnsd_pkg::MODE_LOWER5, 1'b0);
  endtask

  // One-byte strings at the byte extremes
  task automatic test_single_byte_extremes();
    send_byte(8'hFF, pnsd_pkg::MODE_LOWER5, 1'b1);
    send_byte(8'h00, pnsd_pkg::MODE_MIXED6, 1'b1);
  endtask

  // Both registers at their extremes, swapped, then random
  task automatic test_register_extremes();
    write_special(pnsd_pkg::CFG_SPECIAL_ONE, 8'h00);
    write_special(pnsd_pkg::CFG_SPECIAL_TWO, 8'hFF);
    code_buf = '{6'd62, 6'd63, 6'd62};
    send_packed(1'b0, pnsd_pkg::MODE_MIXED6, 1'b0);
    write_special(pnsd_pkg::CFG_SPECIAL_ONE, 8'hFF);
    write_special(pnsd_pkg::CFG_SPECIAL_TWO, 8'h00);
    code_buf = '{6'd63, 6'd62, 6'd63};
    send_packed(1'b0, pnsd_pkg::MODE_MIXED6, 1'b0);
    write_special(pnsd_pkg::CFG_SPECIAL_ONE, 8'($urandom_range(0, 255)));
    write_special(pnsd_pkg::CFG_SPECIAL_TWO, 8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed strings with random content, the rest raw noise
  task automatic test_random_strings();
    int         pick;
    int         n;
    logic [1:0] m;
    logic [5:0] c;
    while (items_live < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      m    = 2'($urandom_range(0, 3));
      if (pick < 3) begin
        write_special(pnsd_pkg::CFG_IDX_W'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (pick < 76) begin
        code_buf.delete();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
        repeat (n) begin
          if (m == pnsd_pkg::MODE_MIXED6) c = 6'($urandom_range(0, 63));
          else if ($urandom_range(0, 19) == 0) c = 6'($urandom_range(30, 31));
          else if ($urandom_range(0, 4) == 0) c = 6'd29;
          else c = 6'($urandom_range(0, 28));
          code_buf.insert(code_buf.size(), c);
        end
        send_packed(1'($urandom_range(0, 1)), m, $urandom_range(0, 9) == 0);
      end else begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++)
          send_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                    (j == n - 1) || ($urandom_range(0, 4) == 0));
        strings_sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_mode      = pnsd_pkg::MODE_LOWER5;
    in_last_byte = 1'b0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = pnsd_pkg::CFG_SPECIAL_ONE;
    cfg_data     = 8'h00;
    spec_one     = pnsd_pkg::SPECIAL_ONE_RST;
    spec_two     = pnsd_pkg::SPECIAL_TWO_RST;
    burst_left   = 0;
    items_live   = 0;
    strings_sent = 0;
    results_seen = 0;
    bad_ends     = 0;
    cfg_writes   = 0;
    err_count    = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    stall_style  = 0;
    clear_string();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_specials_at_reset();
    test_lower5_strip();
    test_first_upper();
    test_escape_upper();
    settle_block();
    test_bad_code();
    test_single_byte_extremes();
    test_register_extremes();
    test_random_strings();

    settle_block();
    if (chars_due.size() != 0)
      note_mismatch("results never returned", 8'(chars_due.size()), 8'h00);
    $display("Sent %0d bytes in %0d strings with %0d register writes;",
             items_live, strings_sent, cfg_writes);
    $display("checked %0d results, %0d of them bad-code ends, %0d mismatches.",
             results_seen, bad_ends, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
